### design/ctsc_pkg.sv
// Shared types, constants and helpers for the column-to-span converter.
`timescale 1ns / 1ps
`default_nettype none
package ctsc_pkg;

  localparam int ROW_W   = 6;  // row index, 0..ROWS-1
  localparam int TOP_W   = 7;  // top extent, ROWS marks an empty column
  localparam int COL_W   = 9;  // incoming column, 0..511
  localparam int START_W = 8;  // stored start column and span end

  localparam logic [TOP_W-1:0] ROWS = 7'd64;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [TOP_W-1:0] prev_top;
    logic [ROW_W-1:0] prev_bottom;
    logic [TOP_W-1:0] cur_top;
    logic [ROW_W-1:0] cur_bottom;
  } ctsc_in_t;

  typedef struct packed {
    logic [ROW_W-1:0]   span_row;
    logic [START_W-1:0] span_start;
    logic [START_W-1:0] span_end;
    logic               last_span;
  } ctsc_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLOSE_TOP,
    ST_CLOSE_BOT,
    ST_OPEN_TOP,
    ST_OPEN_BOT
  } ctsc_state_e;

  // Start store access, one per cycle.
  typedef struct packed {
    logic               re;
    logic               we;
    logic [ROW_W-1:0]   addr;
    logic [START_W-1:0] wdata;
  } ctsc_mem_req_t;

  // Span fields that travel alongside a start store read.
  typedef struct packed {
    logic               vld;
    logic [ROW_W-1:0]   row;
    logic [START_W-1:0] span_end;
    logic               last;
  } ctsc_rd_tag_t;

  function automatic logic [TOP_W-1:0] ctsc_clamp_top(input logic [TOP_W-1:0] t);
    return (t > ROWS) ? ROWS : t;
  endfunction

endpackage
`default_nettype wire

### design/column_to_span_converter_core.sv
// Top level of the column-to-span converter.
`timescale 1ns / 1ps
`default_nettype none
// Column-to-span converter. Each input item carries a column number and the
// row extents (top, bottom) of the previous and current column of a plane; a
// top of 64 or more marks an empty column. Rows covered only by the previous
// column close and each yields one span item: its row, the start column kept
// for that row, and column - 1 (low 8 bits, so column 0 gives 255). Closed top
// rows come out ascending, then closed bottom rows descending; last_span marks
// the final span of an item, and an item that closes no row yields nothing.
// Rows covered only by the current column get the current column (low 8 bits)
// recorded as their start. The start store is a 64 x 8 single-port RAM with
// a registered read and no reset; reading a row that was never opened
// returns whatever the RAM holds. One item is in work at a time: after
// accept the walker visits four phases, and the store port serves one row
// per cycle, though a closing row's read waits while the output stage has
// no free slot. Span items leave through an output register, one per cycle
// when the consumer keeps ready high; a stalled output holds the walker.
module column_to_span_converter_core
  import ctsc_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  ctsc_in_t   in_data_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output ctsc_out_t  out_data_o
);

  ctsc_mem_req_t      mem_req;
  ctsc_rd_tag_t       rd_tag;
  logic [START_W-1:0] rdata;
  logic               rd_free;

  // walker: accepts an item and issues row reads / start writes
  ctsc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_ready_o (in_ready_o),
    .rd_free_i  (rd_free),
    .mem_req_o  (mem_req),
    .rd_tag_o   (rd_tag)
  );

  // per-row start column store
  ctsc_start_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // read data meets its tag and lands in the output register
  ctsc_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_tag_i    (rd_tag),
    .rdata_i     (rdata),
    .rd_free_o   (rd_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

### design/ctsc_start_mem.sv
// Row start column store: 64 x 8 single-port RAM, registered read.
`timescale 1ns / 1ps
`default_nettype none
module ctsc_start_mem
  import ctsc_pkg::*;
(
  input  wire                 clk_i,
  input  ctsc_mem_req_t       req_i,
  output logic [START_W-1:0]  rdata_o
);

  logic [START_W-1:0] mem_q [ROWS];
  logic [START_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    // read data holds until the next read
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### design/ctsc_seq.sv
// Row walker: steps through closing and opening rows, one store access per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ctsc_seq
  import ctsc_pkg::*;
(
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  input  ctsc_in_t       in_data_i,
  output logic           in_ready_o,
  input  wire            rd_free_i,
  output ctsc_mem_req_t  mem_req_o,
  output ctsc_rd_tag_t   rd_tag_o
);

  ctsc_state_e state_q, state_d;

  logic [TOP_W-1:0]   t1_q, t1_d, t2_q, t2_d;
  logic [ROW_W-1:0]   b1_q, b1_d, b2_q, b2_d;
  logic [START_W-1:0] col_q, col_d;

  logic               accept;
  logic               close_top, close_bot, open_top, open_bot;
  logic [TOP_W-1:0]   t1_nxt, b1_ext, b1m_ext, b2_ext;
  logic [ROW_W-1:0]   b1_m1;
  logic               more_after_top, more_after_bot;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // walk conditions
  always_comb begin
    b1_ext   = {1'b0, b1_q};
    b2_ext   = {1'b0, b2_q};
    b1_m1    = b1_q - 1'b1;
    b1m_ext  = {1'b0, b1_m1};
    t1_nxt   = t1_q + 1'b1;

    close_top = (t1_q < t2_q) && (t1_q <= b1_ext);
    close_bot = (b1_q > b2_q) && (b1_ext >= t1_q);
    open_top  = (t2_q < t1_q) && (t2_q <= b2_ext);
    open_bot  = (b2_q > b1_q) && (b2_ext >= t2_q);

    more_after_top = ((t1_nxt < t2_q) && (t1_nxt <= b1_ext)) ||
                     ((b1_q > b2_q) && (b1_ext >= t1_nxt));
    more_after_bot = (b1_m1 > b2_q) && (b1m_ext >= t1_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (accept) state_d = ST_CLOSE_TOP;
      ST_CLOSE_TOP: if (!close_top) state_d = ST_CLOSE_BOT;
      ST_CLOSE_BOT: if (!close_bot) state_d = ST_OPEN_TOP;
      ST_OPEN_TOP:  if (!open_top) state_d = ST_OPEN_BOT;
      ST_OPEN_BOT:  if (!open_bot) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // store accesses and extent counters
  always_comb begin
    t1_d  = t1_q;
    t2_d  = t2_q;
    b1_d  = b1_q;
    b2_d  = b2_q;
    col_d = col_q;
    mem_req_o = '0;
    rd_tag_o  = '0;
    rd_tag_o.span_end = col_q - 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          t1_d  = ctsc_clamp_top(in_data_i.prev_top);
          t2_d  = ctsc_clamp_top(in_data_i.cur_top);
          b1_d  = in_data_i.prev_bottom;
          b2_d  = in_data_i.cur_bottom;
          col_d = in_data_i.column[START_W-1:0];
        end
      end
      ST_CLOSE_TOP: begin
        if (close_top && rd_free_i) begin
          mem_req_o.re  = 1'b1;
          mem_req_o.addr = t1_q[ROW_W-1:0];
          rd_tag_o.vld  = 1'b1;
          rd_tag_o.row  = t1_q[ROW_W-1:0];
          rd_tag_o.last = !more_after_top;
          t1_d = t1_nxt;
        end
      end
      ST_CLOSE_BOT: begin
        if (close_bot && rd_free_i) begin
          mem_req_o.re  = 1'b1;
          mem_req_o.addr = b1_q;
          rd_tag_o.vld  = 1'b1;
          rd_tag_o.row  = b1_q;
          rd_tag_o.last = !more_after_bot;
          b1_d = b1_m1;
        end
      end
      ST_OPEN_TOP: begin
        if (open_top) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.addr  = t2_q[ROW_W-1:0];
          mem_req_o.wdata = col_q;
          t2_d = t2_q + 1'b1;
        end
      end
      ST_OPEN_BOT: begin
        if (open_bot) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.addr  = b2_q;
          mem_req_o.wdata = col_q;
          b2_d = b2_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q  <= t1_d;
    t2_q  <= t2_d;
    b1_q  <= b1_d;
    b2_q  <= b2_d;
    col_q <= col_d;
  end

  a_idle_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!mem_req_o.re && !mem_req_o.we))
    else $error("store access while idle");

  a_one_port : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req_o.re && mem_req_o.we))
    else $error("read and write in one cycle");

  a_read_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.re |-> (rd_free_i && rd_tag_o.vld))
    else $error("read issued without a free slot");

endmodule
`default_nettype wire

### design/ctsc_emit.sv
// Span output stage: pairs read data with its tag and holds the result item.
`timescale 1ns / 1ps
`default_nettype none
module ctsc_emit
  import ctsc_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  ctsc_rd_tag_t        rd_tag_i,
  input  wire [START_W-1:0]   rdata_i,
  output logic                rd_free_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output ctsc_out_t           out_data_o
);

  ctsc_rd_tag_t tag_q;
  logic         pend_q;
  logic         out_valid_q;
  ctsc_out_t    out_q;
  logic         load_out;

  assign load_out  = pend_q && (!out_valid_q || out_ready_i);
  assign rd_free_o = !pend_q || load_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rd_free_o) begin
        pend_q <= rd_tag_i.vld;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_free_o && rd_tag_i.vld) begin
      tag_q <= rd_tag_i;
    end
    if (load_out) begin
      out_q.span_row   <= tag_q.row;
      out_q.span_start <= rdata_i;
      out_q.span_end   <= tag_q.span_end;
      out_q.last_span  <= tag_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_no_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && !load_out) |=> pend_q)
    else $error("pending read lost");

  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_tag_i.vld && !rd_free_o) |-> 1'b0)
    else $error("read issued over a pending read");

  a_load_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_q)
    else $error("loaded item not presented");

endmodule
`default_nettype wire
